// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ipd_pkg.sv
// Types and constants for the IMU packet deframer.
// No dependencies; used by ipd_walker and imu_packet_deframer.
package ipd_pkg;

    // Receive phases of the frame parser.
    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_DESC,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHK_HI,
        PH_CHK_LO
    } phase_t;

    // Field walk sequencer states.
    typedef enum logic [2:0] {
        W_IDLE,
        W_HEAD,
        W_FLEN,
        W_DESC,
        W_DATA,
        W_EMIT,
        W_STATUS
    } walk_state_t;

    // Result kinds.
    localparam logic [2:0] KIND_BAD   = 3'd0;
    localparam logic [2:0] KIND_OK    = 3'd1;
    localparam logic [2:0] KIND_ACCEL = 3'd2;
    localparam logic [2:0] KIND_GYRO  = 3'd3;
    localparam logic [2:0] KIND_MAG   = 3'd4;
    localparam logic [2:0] KIND_BARO  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [2:0] CFG_IMU_CLASS   = 3'd2;
    localparam logic [2:0] CFG_ACCEL       = 3'd3;
    localparam logic [2:0] CFG_GYRO        = 3'd4;
    localparam logic [2:0] CFG_MAG         = 3'd5;
    localparam logic [2:0] CFG_BARO        = 3'd6;

    // Configuration reset values.
    localparam logic [7:0] RST_SYNC_FIRST  = 8'd117;
    localparam logic [7:0] RST_SYNC_SECOND = 8'd101;
    localparam logic [7:0] RST_IMU_CLASS   = 8'd128;
    localparam logic [7:0] RST_ACCEL       = 8'd4;
    localparam logic [7:0] RST_GYRO        = 8'd5;
    localparam logic [7:0] RST_MAG         = 8'd6;
    localparam logic [7:0] RST_BARO        = 8'd23;

    // Field layout: length byte, descriptor byte, then data.
    localparam logic [7:0] MIN_FIELD_LEN = 8'd3;
    localparam logic [7:0] TRIPLE_LEN    = 8'd14;  // header plus three words
    localparam logic [7:0] SINGLE_LEN    = 8'd6;   // header plus one word
    localparam logic [3:0] TRIPLE_LAST   = 4'd11;  // last data byte offset
    localparam logic [3:0] SINGLE_LAST   = 4'd3;

    // Field descriptor codes handed to the walker.
    typedef struct packed {
        logic [7:0] accel;
        logic [7:0] gyro;
        logic [7:0] mag;
        logic [7:0] baro;
    } field_codes_t;

    // Request from the frame parser to the walker at packet end.
    typedef struct packed {
        logic       start;
        logic       walk;
        logic       good;
        logic [7:0] code;
        logic [7:0] len;
    } walk_req_t;

endpackage

// File: hw/rtl/ipd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ipd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/ipd_walker.sv
// Field walk sequencer: reads the payload RAM one byte per cycle unless stalled,
// assembles field words and drives the result register. Depends on ipd_pkg.
`include "assert_macros.svh"

module ipd_walker #(
    parameter int ADDR_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipd_pkg::walk_req_t   req,
    input  ipd_pkg::field_codes_t codes,
    output logic                 busy,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [7:0]           rd_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [103:0]         m_tdata,   // packet_code, word_x, word_y, word_z
    output logic [2:0]           m_tuser,   // kind
    output logic                 m_tlast
);
    import ipd_pkg::*;

    walk_state_t st_reg, st_next;
    logic [8:0]  i_reg, i_next;
    logic [7:0]  flen_reg, flen_next;
    logic [2:0]  kind_reg, kind_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  need_last_reg, need_last_next;
    logic [95:0] acc_reg, acc_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  len_reg, len_next;
    logic        good_reg, good_next;
    logic        seen_accel_reg, seen_accel_next;
    logic        seen_gyro_reg, seen_gyro_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic [7:0]  out_code_reg, out_code_next;
    logic [31:0] out_x_reg, out_x_next;
    logic [31:0] out_y_reg, out_y_next;
    logic [31:0] out_z_reg, out_z_next;
    logic        out_last_reg, out_last_next;

    logic        out_free;
    logic [3:0]  offset;
    logic [8:0]  addr_sum;
    logic [8:0]  field_end;
    logic        triple_ok;
    logic        single_ok;
    logic        dec_emit;
    logic [2:0]  dec_kind;
    logic [3:0]  dec_last;
    logic        dec_set_accel;
    logic        dec_set_gyro;

    // Shared address adder: field start plus the offset of the byte wanted.
    always_comb
    begin
        case (st_reg)
            W_FLEN:  offset = 4'd1;
            W_DESC:  offset = 4'd2;
            W_DATA:  offset = cnt_reg + 4'd3;
            default: offset = 4'd0;
        endcase
        addr_sum  = i_reg + {5'd0, offset};
        field_end = i_reg + {1'b0, rd_data};
    end

    assign rd_addr  = addr_sum[ADDR_W-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign busy     = (st_reg != W_IDLE);

    // Descriptor decode, in accel, gyro, mag, baro priority.
    always_comb
    begin
        triple_ok     = (flen_reg >= TRIPLE_LEN);
        single_ok     = (flen_reg >= SINGLE_LEN);
        dec_emit      = 1'b0;
        dec_kind      = KIND_MAG;
        dec_last      = TRIPLE_LAST;
        dec_set_accel = 1'b0;
        dec_set_gyro  = 1'b0;
        if (rd_data == codes.accel)
        begin
            dec_kind = KIND_ACCEL;
            if (triple_ok)
            begin
                dec_emit      = seen_accel_reg;
                dec_set_accel = !seen_accel_reg;
            end
        end
        else if (rd_data == codes.gyro)
        begin
            dec_kind = KIND_GYRO;
            if (triple_ok)
            begin
                dec_emit     = seen_gyro_reg;
                dec_set_gyro = !seen_gyro_reg;
            end
        end
        else if (rd_data == codes.mag)
        begin
            dec_kind = KIND_MAG;
            dec_emit = triple_ok;
        end
        else if (rd_data == codes.baro)
        begin
            dec_kind = KIND_BARO;
            dec_last = SINGLE_LAST;
            dec_emit = single_ok;
        end
    end

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    st_next = req.walk ? W_HEAD : W_STATUS;
                end
            end
            W_HEAD:
            begin
                st_next = (i_reg >= {1'b0, len_reg}) ? W_STATUS : W_FLEN;
            end
            W_FLEN:
            begin
                if (rd_data < MIN_FIELD_LEN || field_end > {1'b0, len_reg})
                begin
                    st_next = W_STATUS;
                end
                else
                begin
                    st_next = W_DESC;
                end
            end
            W_DESC:
            begin
                st_next = dec_emit ? W_DATA : W_HEAD;
            end
            W_DATA:
            begin
                if (cnt_reg == need_last_reg)
                begin
                    st_next = W_EMIT;
                end
            end
            W_EMIT:
            begin
                if (out_free)
                begin
                    st_next = W_HEAD;
                end
            end
            W_STATUS:
            begin
                if (out_free)
                begin
                    st_next = W_IDLE;
                end
            end
            default:
            begin
                st_next = W_IDLE;
            end
        endcase
    end

    // Datapath and result register updates.
    always_comb
    begin
        i_next          = i_reg;
        flen_next       = flen_reg;
        kind_next       = kind_reg;
        cnt_next        = cnt_reg;
        need_last_next  = need_last_reg;
        acc_next        = acc_reg;
        code_next       = code_reg;
        len_next        = len_reg;
        good_next       = good_reg;
        seen_accel_next = seen_accel_reg;
        seen_gyro_next  = seen_gyro_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_code_next   = out_code_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_z_next      = out_z_reg;
        out_last_next   = out_last_reg;
        case (st_reg)
            W_IDLE:
            begin
                if (req.start)
                begin
                    i_next    = 9'd0;
                    code_next = req.code;
                    len_next  = req.len;
                    good_next = req.good;
                end
            end
            W_FLEN:
            begin
                flen_next = rd_data;
            end
            W_DESC:
            begin
                kind_next       = dec_kind;
                need_last_next  = dec_last;
                cnt_next        = 4'd0;
                seen_accel_next = seen_accel_reg || dec_set_accel;
                seen_gyro_next  = seen_gyro_reg || dec_set_gyro;
                if (!dec_emit)
                begin
                    i_next = i_reg + {1'b0, flen_reg};
                end
            end
            W_DATA:
            begin
                acc_next = {acc_reg[87:0], rd_data};
                cnt_next = cnt_reg + 4'd1;
            end
            W_EMIT:
            begin
                if (out_free)
                begin
                    i_next         = i_reg + {1'b0, flen_reg};
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_code_next  = code_reg;
                    out_last_next  = 1'b0;
                    if (kind_reg == KIND_BARO)
                    begin
                        out_x_next = acc_reg[31:0];
                        out_y_next = 32'd0;
                        out_z_next = 32'd0;
                    end
                    else
                    begin
                        out_x_next = acc_reg[95:64];
                        out_y_next = acc_reg[63:32];
                        out_z_next = acc_reg[31:0];
                    end
                end
            end
            W_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = good_reg ? KIND_OK : KIND_BAD;
                    out_code_next  = code_reg;
                    out_x_next     = 32'd0;
                    out_y_next     = 32'd0;
                    out_z_next     = 32'd0;
                    out_last_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= W_IDLE;
            i_reg          <= 9'd0;
            cnt_reg        <= 4'd0;
            seen_accel_reg <= 1'b0;
            seen_gyro_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            i_reg          <= i_next;
            cnt_reg        <= cnt_next;
            seen_accel_reg <= seen_accel_next;
            seen_gyro_reg  <= seen_gyro_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        flen_reg      <= flen_next;
        kind_reg      <= kind_next;
        need_last_reg <= need_last_next;
        acc_reg       <= acc_next;
        code_reg      <= code_next;
        len_reg       <= len_next;
        good_reg      <= good_next;
        out_kind_reg  <= out_kind_next;
        out_code_reg  <= out_code_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_z_reg     <= out_z_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_z_reg, out_y_reg, out_x_reg, out_code_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // The walk position never passes the payload end when a field header is due.
    `ASSERT_IMPLIES(a_head_in_range, st_reg == W_HEAD, i_reg <= {1'b0, len_reg},
        "walk position past payload end")
    // Field results never close a packet, and status results always do.
    `ASSERT_IMPLIES(a_last_is_status, out_valid_reg,
        out_last_reg == (out_kind_reg == KIND_BAD || out_kind_reg == KIND_OK),
        "last flag does not match result kind")
    // The first-field flags are sticky.
    `ASSERT_ALWAYS(a_seen_sticky, !$fell(seen_accel_reg) && !$fell(seen_gyro_reg),
        "seen flag cleared")

endmodule

// File: hw/rtl/imu_packet_deframer.sv
// IMU packet deframer top level: frame parser, checksum, configuration,
// payload RAM and field walker. Depends on ipd_pkg, ipd_ram, ipd_walker.
//
// Usage: received bytes enter on s_tvalid/s_tready/s_tdata, one byte per
// request. The parser hunts for the two sync bytes, then takes descriptor,
// length, payload (stored in the payload RAM) and a two-byte check.
// After the last check byte, for a good check and IMU class descriptor, the
// walker reads the payload RAM one byte per cycle: for each field it fetches
// the length and descriptor header, then 12 data bytes (4 for baro) of each
// emitted field, hands each result over, and at the payload end or a bad
// field issues the closing status, at once for other packets; the single RAM
// read port sets the pace. s_tready is low during the walk. Results leave on
// m_tvalid/m_tready with m_tuser holding the kind and m_tlast marking the
// status result; a stalled receiver holds the walker, and a waiting status
// result does not block the next packet's bytes. Reset returns the parser to
// sync hunt, restores the default codes and clears the first-accel and
// first-gyro flags; the RAM is not cleared. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect as soon as they are registered.
`include "assert_macros.svh"

module imu_packet_deframer #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // packet_code, word_x, word_y, word_z
    output logic [2:0]   m_tuser,   // kind
    output logic         m_tlast,   // last
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [7:0]   cfg_data
);
    import ipd_pkg::*;

    localparam int AddrW = $clog2(PAYLOAD_DEPTH);

    phase_t     ph_reg, ph_next;
    logic [7:0] pkt_desc_reg, pkt_desc_next;
    logic [7:0] pkt_len_reg, pkt_len_next;
    logic [7:0] byte_index_reg, byte_index_next;
    logic [7:0] sum_low_reg, sum_low_next;
    logic [7:0] sum_high_reg, sum_high_next;
    logic [7:0] chk_hi_reg, chk_hi_next;

    logic [7:0] sync_first_reg, sync_second_reg, imu_class_reg;
    logic [7:0] accel_code_reg, gyro_code_reg, mag_code_reg, baro_code_reg;

    logic             rx_fire;
    logic [7:0]       add_low;
    logic [7:0]       add_high;
    logic [7:0]       index_inc;
    logic             chk_good;
    logic             ram_we;
    logic [AddrW-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             w_busy;
    walk_req_t        req;
    field_codes_t     codes;

    assign s_tready  = !w_busy;
    assign rx_fire   = s_tvalid && s_tready;
    assign add_low   = sum_low_reg + s_tdata;
    assign add_high  = sum_high_reg + add_low;
    assign index_inc = byte_index_reg + 8'd1;
    assign chk_good  = (chk_hi_reg == sum_low_reg) && (s_tdata == sum_high_reg);

    // Next phase of the frame parser.
    always_comb
    begin
        ph_next = ph_reg;
        if (rx_fire)
        begin
            case (ph_reg)
                PH_SYNC1:   ph_next = (s_tdata == sync_first_reg) ? PH_SYNC2 : PH_SYNC1;
                PH_SYNC2:   ph_next = (s_tdata == sync_second_reg) ? PH_DESC : PH_SYNC1;
                PH_DESC:    ph_next = PH_LEN;
                PH_LEN:     ph_next = (s_tdata == 8'd0) ? PH_CHK_HI : PH_PAYLOAD;
                PH_PAYLOAD: ph_next = (index_inc >= pkt_len_reg) ? PH_CHK_HI : PH_PAYLOAD;
                PH_CHK_HI:  ph_next = PH_CHK_LO;
                PH_CHK_LO:  ph_next = PH_SYNC1;
                default:    ph_next = PH_SYNC1;
            endcase
        end
    end

    // Frame fields, running check sums, RAM write and walk request.
    always_comb
    begin
        pkt_desc_next   = pkt_desc_reg;
        pkt_len_next    = pkt_len_reg;
        byte_index_next = byte_index_reg;
        sum_low_next    = sum_low_reg;
        sum_high_next   = sum_high_reg;
        chk_hi_next     = chk_hi_reg;
        ram_we          = 1'b0;
        req             = '0;
        req.code        = pkt_desc_reg;
        req.len         = pkt_len_reg;
        req.good        = chk_good;
        req.walk        = chk_good && (pkt_desc_reg == imu_class_reg);
        if (rx_fire)
        begin
            case (ph_reg)
                PH_SYNC1:
                begin
                    if (s_tdata == sync_first_reg)
                    begin
                        sum_low_next  = s_tdata;
                        sum_high_next = s_tdata;
                    end
                end
                PH_SYNC2:
                begin
                    if (s_tdata == sync_second_reg)
                    begin
                        sum_low_next  = add_low;
                        sum_high_next = add_high;
                    end
                    else
                    begin
                        pkt_desc_next   = 8'd0;
                        pkt_len_next    = 8'd0;
                        byte_index_next = 8'd0;
                        sum_low_next    = 8'd0;
                        sum_high_next   = 8'd0;
                        chk_hi_next     = 8'd0;
                    end
                end
                PH_DESC:
                begin
                    pkt_desc_next = s_tdata;
                    sum_low_next  = add_low;
                    sum_high_next = add_high;
                end
                PH_LEN:
                begin
                    pkt_len_next    = s_tdata;
                    byte_index_next = 8'd0;
                    sum_low_next    = add_low;
                    sum_high_next   = add_high;
                end
                PH_PAYLOAD:
                begin
                    ram_we          = 1'b1;
                    byte_index_next = index_inc;
                    sum_low_next    = add_low;
                    sum_high_next   = add_high;
                end
                PH_CHK_HI:
                begin
                    chk_hi_next = s_tdata;
                end
                PH_CHK_LO:
                begin
                    req.start       = 1'b1;
                    pkt_desc_next   = 8'd0;
                    pkt_len_next    = 8'd0;
                    byte_index_next = 8'd0;
                    sum_low_next    = 8'd0;
                    sum_high_next   = 8'd0;
                    chk_hi_next     = 8'd0;
                end
                default:
                begin
                    pkt_desc_next   = 8'd0;
                    pkt_len_next    = 8'd0;
                    byte_index_next = 8'd0;
                    sum_low_next    = 8'd0;
                    sum_high_next   = 8'd0;
                    chk_hi_next     = 8'd0;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg         <= PH_SYNC1;
            pkt_desc_reg   <= 8'd0;
            pkt_len_reg    <= 8'd0;
            byte_index_reg <= 8'd0;
            sum_low_reg    <= 8'd0;
            sum_high_reg   <= 8'd0;
            chk_hi_reg     <= 8'd0;
        end
        else
        begin
            ph_reg         <= ph_next;
            pkt_desc_reg   <= pkt_desc_next;
            pkt_len_reg    <= pkt_len_next;
            byte_index_reg <= byte_index_next;
            sum_low_reg    <= sum_low_next;
            sum_high_reg   <= sum_high_next;
            chk_hi_reg     <= chk_hi_next;
        end
    end

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= RST_SYNC_FIRST;
            sync_second_reg <= RST_SYNC_SECOND;
            imu_class_reg   <= RST_IMU_CLASS;
            accel_code_reg  <= RST_ACCEL;
            gyro_code_reg   <= RST_GYRO;
            mag_code_reg    <= RST_MAG;
            baro_code_reg   <= RST_BARO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                CFG_IMU_CLASS:   imu_class_reg   <= cfg_data;
                CFG_ACCEL:       accel_code_reg  <= cfg_data;
                CFG_GYRO:        gyro_code_reg   <= cfg_data;
                CFG_MAG:         mag_code_reg    <= cfg_data;
                CFG_BARO:        baro_code_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign codes.accel = accel_code_reg;
    assign codes.gyro  = gyro_code_reg;
    assign codes.mag   = mag_code_reg;
    assign codes.baro  = baro_code_reg;

    // Payload buffer.
    ipd_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (byte_index_reg[AddrW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Field walker and result register.
    ipd_walker #(
        .ADDR_W (AddrW)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .codes    (codes),
        .busy     (w_busy),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The walker only runs between frames.
    `ASSERT_IMPLIES(a_walk_between_frames, w_busy, ph_reg == PH_SYNC1,
        "walker busy while a frame is being received")
    // Payload phase is only entered with a nonzero length.
    `ASSERT_IMPLIES(a_payload_len, ph_reg == PH_PAYLOAD, pkt_len_reg != 8'd0,
        "payload phase with zero length")
    // The write index stays inside the announced payload.
    `ASSERT_IMPLIES(a_payload_index, ph_reg == PH_PAYLOAD, byte_index_reg < pkt_len_reg,
        "payload index past length")

endmodule
